// ===== design/ntt_pkg.sv =====
// shared types and constants for the mod 65537 number theoretic transform
`timescale 1ns / 1ps
package ntt_pkg;

   localparam int unsigned ResWidth  = 17;
   localparam int unsigned MaxPoints = 1024;
   localparam logic [16:0] Prime     = 17'd65537;
   localparam logic [16:0] Gen       = 17'd3;
   localparam logic [16:0] GenInv    = 17'd21846;

   // item kinds
   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_RUN   = 2'd1,
      KIND_READ  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   // configuration register indexes
   localparam logic CSR_LOG_SIZE = 1'b0;
   localparam logic CSR_INVERSE  = 1'b1;

   // request to the shared modular multiplier
   typedef struct packed {
      logic        start;
      logic [16:0] a;
      logic [16:0] b;
   } mul_req_type;

   typedef struct packed {
      logic        done;
      logic [16:0] product;
   } mul_rsp_type;

   // reduce x < 2^34 modulo 65537 using 2^16 = -1
   function automatic logic [16:0] reduce34(input logic [33:0] x);
      logic [17:0] lo;
      logic [17:0] hi;
      logic [18:0] t;
      lo = {2'b00, x[15:0]} + {16'd0, x[33:32]};
      hi = {2'b00, x[31:16]};
      t  = {1'b0, lo} + {1'b0, Prime, 1'b0} - {1'b0, hi};
      // t < 3*Prime + 2, subtract up to twice
      if (t >= {1'b0, Prime, 1'b0}) t = t - {1'b0, Prime, 1'b0};
      if (t >= {2'b00, Prime}) t = t - {2'b00, Prime};
      return t[16:0];
   endfunction

endpackage

// ===== design/ntt_mul.sv =====
// shared modular multiplier, with a multiply stage and a reduce stage from start to done
`timescale 1ns / 1ps
module ntt_mul (
   input  logic               clock,
   input  logic               reset,
   input  ntt_pkg::mul_req_type req,
   output ntt_pkg::mul_rsp_type rsp
);
   import ntt_pkg::*;

   logic [33:0] prod_ff;
   logic [33:0] prod_in;
   logic        stage_ff;
   logic        stage_in;
   logic        done_ff;
   logic        done_in;
   logic [16:0] res_ff;
   logic [16:0] res_in;

   // multiply stage then reduce stage
   always_comb begin
      prod_in  = req.a * req.b;
      stage_in = req.start;
      done_in  = stage_ff;
      res_in   = reduce34(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         done_ff  <= done_in;
      end
      prod_ff <= prod_in;
      res_ff  <= res_in;
   end

   assign rsp.done    = done_ff;
   assign rsp.product = res_ff;

endmodule

// ===== design/ntt_radix2_mod_65537.sv =====
// top level: coefficient and work memories with the transform sequencer
//
// channel | direction | tdata fields (low first)            | tuser
// req     | in        | index[9:0] value_in[26:10] pad       | kind[1:0]
// rsp     | out       | value_out[16:0] index_out[26:17] pad | none
// csr     | in        | log_size or inverse_mode             | none
//
// a write is stored when it is taken; a read passes through RDWAIT and RDOUT
// before its result shows; a run copies each point in bit-reversed order
// (COPY, CPWR), then per stage s sets up, squares the root 16-s times and does
// each butterfly with its twiddle step, then in inverse mode scales each point
// reset is synchronous and does not clear the memories.
// req_tready stays low while a run or a read result is in flight.
`timescale 1ns / 1ps
module ntt_radix2_mod_65537 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // index, value_in
   input  logic [1:0]  req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // value_out, index_out
   input  logic        csr_wen,
   input  logic        csr_index,
   input  logic [3:0]  csr_wdata
);
   import ntt_pkg::*;

   localparam int unsigned AW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
   localparam logic [4:0] MaxLog = (AW > 16) ? 5'd16 : 5'(AW);

   typedef enum logic [13:0] {
      ST_IDLE   = 14'b00000000000001,
      ST_RDWAIT = 14'b00000000000010,
      ST_RDOUT  = 14'b00000000000100,
      ST_COPY   = 14'b00000000001000,
      ST_CPWR   = 14'b00000000010000,
      ST_STAGE  = 14'b00000000100000,
      ST_SQ     = 14'b00000001000000,
      ST_BFRD   = 14'b00000010000000,
      ST_BFRD2  = 14'b00000100000000,
      ST_BFMUL  = 14'b00001000000000,
      ST_BFWR   = 14'b00010000000000,
      ST_TWID   = 14'b00100000000000,
      ST_SCRD   = 14'b01000000000000,
      ST_SCMUL  = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [3:0]  log_ff;
   logic        inv_ff;
   logic [4:0]  efflog;

   // memories
   logic [16:0] coeff_mem [MaxPoints];
   logic [16:0] work_mem  [MaxPoints];
   logic [16:0] crd_ff;
   logic [16:0] wrd_ff;
   logic        cwe;
   logic [AW-1:0] cwa;
   logic [16:0] cwd;
   logic [AW-1:0] cra;
   logic        wwe;
   logic [AW-1:0] wwa;
   logic [16:0] wwd;
   logic [AW-1:0] wra;

   // sequencer registers
   logic [AW:0]   i_ff, i_in;
   logic [4:0]    s_ff, s_in;
   logic [4:0]    k_ff, k_in;
   logic [AW:0]   start_ff, start_in;
   logic [AW:0]   j_ff, j_in;
   logic [16:0]   w_ff, w_in;
   logic [16:0]   m_ff, m_in;
   logic [16:0]   a_ff, a_in;
   logic [16:0]   t_ff, t_in;
   logic [AW:0]   n;
   logic [AW:0]   half;
   logic [9:0]    ridx_ff, ridx_in;
   logic [16:0]   rval_ff, rval_in;
   logic          rvalid_ff, rvalid_in;
   logic          mwait_ff, mwait_in;
   mul_req_type   mreq;
   mul_rsp_type   mrsp;
   logic [AW-1:0] rev;
   logic [17:0]   sum;
   logic [17:0]   dif;
   logic [9:0]    idx;
   logic [16:0]   vin;
   logic          acc;
   logic [16:0]   ninv;

   assign idx = req_tdata[9:0];
   assign vin = req_tdata[26:10];
   assign acc = req_tvalid && req_tready;

   ntt_mul u_mul (.clock(clock), .reset(reset), .req(mreq), .rsp(mrsp));

   // effective length
   always_comb begin
      efflog = {1'b0, log_ff};
      if (efflog < 5'd1) efflog = 5'd1;
      if (efflog > MaxLog) efflog = MaxLog;
      n    = (AW+1)'(1) << efflog;
      half = (AW+1)'(1) << (s_ff - 5'd1);
      ninv = Prime - 17'(17'h10000 >> efflog);
   end

   // bit reverse of the copy counter over efflog bits
   always_comb begin
      rev = '0;
      for (int b = 0; b < AW; b++) begin
         if (b < int'(efflog)) rev[int'(efflog) - 1 - b] = i_ff[b];
      end
   end

   // butterfly add and subtract
   always_comb begin
      sum = {1'b0, a_ff} + {1'b0, t_ff};
      if (sum >= {1'b0, Prime}) sum = sum - {1'b0, Prime};
      dif = (a_ff >= t_ff) ? {1'b0, a_ff} - {1'b0, t_ff}
                           : {1'b0, a_ff} + {1'b0, Prime} - {1'b0, t_ff};
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      i_in = i_ff; s_in = s_ff; k_in = k_ff; start_in = start_ff; j_in = j_ff;
      w_in = w_ff; m_in = m_ff; a_in = a_ff; t_in = t_ff;
      ridx_in = ridx_ff; rval_in = rval_ff; rvalid_in = rvalid_ff;
      mwait_in = 1'b0;
      mreq = '{start: 1'b0, a: w_ff, b: w_ff};
      cwe = 1'b0; cwa = idx[AW-1:0]; cwd = vin; cra = idx[AW-1:0];
      wwe = 1'b0; wwa = '0; wwd = '0; wra = idx[AW-1:0];
      req_tready = 1'b0;
      if (rvalid_ff && rsp_tready) rvalid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = !rvalid_ff;
            if (acc) begin
               case (kind_type'(req_tuser))
                  KIND_WRITE: begin
                     cwe = (32'(idx) < MaxPoints);
                     cwd = (vin >= Prime) ? vin - Prime : vin;
                  end
                  KIND_RUN: begin
                     i_in = '0;
                     cra = '0;
                     state_in = ST_COPY;
                  end
                  KIND_READ: begin
                     ridx_in = idx;
                     state_in = ST_RDWAIT;
                  end
                  default: ;
               endcase
            end
         end
         ST_RDWAIT: begin
            wra = ridx_ff[AW-1:0];
            state_in = ST_RDOUT;
         end
         ST_RDOUT: begin
            rval_in = (32'(ridx_ff) < MaxPoints) ? wrd_ff : 17'd0;
            rvalid_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_COPY: begin
            cra = i_ff[AW-1:0];
            state_in = ST_CPWR;
         end
         ST_CPWR: begin
            wwe = 1'b1; wwa = rev; wwd = crd_ff;
            i_in = i_ff + 1'b1;
            if (i_ff + 1'b1 == n) begin
               s_in = 5'd1;
               state_in = ST_STAGE;
            end else state_in = ST_COPY;
         end
         ST_STAGE: begin
            // twiddle root for this stage: base^(2^(16-s))
            w_in = inv_ff ? GenInv : Gen;
            k_in = 5'd16 - s_ff;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            if (!mwait_ff && !mrsp.done) begin
               if (k_ff == 5'd0) begin
                  start_in = '0; j_in = '0; m_in = 17'd1;
                  state_in = ST_BFRD;
               end else begin
                  mreq = '{start: 1'b1, a: w_ff, b: w_ff};
                  mwait_in = 1'b1;
               end
            end else if (mwait_ff) mwait_in = 1'b1;
            if (mrsp.done) begin
               mwait_in = 1'b0;
               w_in = mrsp.product;
               k_in = k_ff - 5'd1;
            end
         end
         ST_BFRD: begin
            wra = AW'(start_ff + j_ff + half);
            state_in = ST_BFRD2;
         end
         ST_BFRD2: begin
            wra = AW'(start_ff + j_ff);
            mreq = '{start: 1'b1, a: m_ff, b: wrd_ff};
            state_in = ST_BFMUL;
         end
         ST_BFMUL: begin
            if (mwait_ff == 1'b0 && !mrsp.done) begin
               a_in = wrd_ff;
               mwait_in = 1'b1;
            end else if (mrsp.done) begin
               t_in = mrsp.product;
               state_in = ST_BFWR;
            end else mwait_in = 1'b1;
         end
         ST_BFWR: begin
            wwe = 1'b1; wwa = AW'(start_ff + j_ff); wwd = sum[16:0];
            mreq = '{start: 1'b1, a: m_ff, b: w_ff};
            state_in = ST_TWID;
         end
         ST_TWID: begin
            if (!mwait_ff && !mrsp.done) begin
               wwe = 1'b1; wwa = AW'(start_ff + j_ff + half); wwd = dif[16:0];
               mwait_in = 1'b1;
            end else if (mrsp.done) begin
               m_in = mrsp.product;
               state_in = ST_BFRD;
               if (j_ff + 1'b1 == half) begin
                  j_in = '0; m_in = 17'd1;
                  if (start_ff + (half << 1) >= n) begin
                     if (s_ff == efflog) begin
                        i_in = '0;
                        state_in = inv_ff ? ST_SCRD : ST_IDLE;
                     end else begin
                        s_in = s_ff + 5'd1;
                        state_in = ST_STAGE;
                     end
                  end else start_in = start_ff + (half << 1);
               end else j_in = j_ff + 1'b1;
            end else mwait_in = 1'b1;
         end
         ST_SCRD: begin
            wra = i_ff[AW-1:0];
            mwait_in = 1'b0;
            state_in = ST_SCMUL;
         end
         ST_SCMUL: begin
            if (!mwait_ff && !mrsp.done) begin
               mreq = '{start: 1'b1, a: wrd_ff, b: ninv};
               mwait_in = 1'b1;
            end else if (mrsp.done) begin
               wwe = 1'b1; wwa = i_ff[AW-1:0]; wwd = mrsp.product;
               i_in = i_ff + 1'b1;
               state_in = (i_ff + 1'b1 == n) ? ST_IDLE : ST_SCRD;
            end else mwait_in = 1'b1;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      if (cwe) coeff_mem[cwa] <= cwd;
      crd_ff <= coeff_mem[cra];
   end

   always_ff @(posedge clock) begin
      if (wwe) work_mem[wwa] <= wwd;
      wrd_ff <= work_mem[wra];
   end

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rvalid_ff <= 1'b0;
         mwait_ff  <= 1'b0;
         log_ff    <= 4'd10;
         inv_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
         mwait_ff  <= mwait_in;
         if (csr_wen && csr_index == CSR_LOG_SIZE) log_ff <= csr_wdata;
         if (csr_wen && csr_index == CSR_INVERSE)  inv_ff <= csr_wdata[0];
      end
      i_ff <= i_in; s_ff <= s_in; k_ff <= k_in; start_ff <= start_in;
      j_ff <= j_in; w_ff <= w_in; m_ff <= m_in; a_ff <= a_in; t_ff <= t_in;
      ridx_ff <= ridx_in; rval_ff <= rval_in;
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {5'd0, ridx_ff, rval_ff};

endmodule

// ===== design/ntt_checker.sv =====
// port-level checks for the transform block, bound to the top level
`timescale 1ns / 1ps
module ntt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);
   import ntt_pkg::*;

   // a result holds while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // a read returns its index
   a_idx: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == KIND_READ
      |-> ##3 rsp_tvalid && rsp_tdata[26:17] == $past(req_tdata[9:0], 3))
      else $error("read result index mismatch");

   // results are residues
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[16:0] <= Prime - 17'd1)
      else $error("result not reduced");

   // no new item while a result waits
   a_block: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input taken while result pending");

endmodule

bind ntt_radix2_mod_65537 ntt_checker u_ntt_checker (.*);

// ===== tb/ntt_radix2_mod_65537_tb.sv =====
// testbench for the mod 65537 radix-2 number theoretic transform
`timescale 1ns / 1ps
module ntt_radix2_mod_65537_tb;
   import ntt_pkg::*;

   localparam int unsigned Points = 1024;
   localparam logic [16:0] Modulus = 17'd65537;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // index[9:0] value_in[26:10] pad
   logic [1:0]  req_tuser;    // kind[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // value_out[16:0] index_out[26:17] pad
   logic        csr_wen;
   logic        csr_index;
   logic [3:0]  csr_wdata;

   // predictor state
   logic [16:0] coeff_mem [Points];
   logic [16:0] spectrum_mem [Points];
   logic [3:0]  log_size_reg;
   logic        inverse_reg;

   typedef struct packed {
      logic [16:0] value;
      logic [9:0]  index;
   } read_result_type;

   read_result_type pending_reads[$];
   int          error_count;
   int          items_sent;
   int          reads_checked;
   int          runs_done;
   int          send_idle_pct;
   int          recv_stall_pct;

   ntt_radix2_mod_65537 uut (.*);

   // clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // generous run limit
   initial begin
      #200ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic logic [16:0] mod_mul(input logic [16:0] a, input logic [16:0] b);
      logic [33:0] prod;
      prod = a * b;
      return 17'(prod % Modulus);
   endfunction

   function automatic logic [16:0] mod_add(input logic [16:0] a, input logic [16:0] b);
      logic [17:0] s;
      s = a + b;
      return (s >= Modulus) ? 17'(s - Modulus) : 17'(s);
   endfunction

   function automatic logic [16:0] mod_sub(input logic [16:0] a, input logic [16:0] b);
      return (a >= b) ? 17'(a - b) : 17'(a + Modulus - b);
   endfunction

   // transform of the predictor's coefficient memory, in place in its spectrum memory
   task automatic predict_transform();
      int          lg;
      int          n;
      int          rev;
      int          span;
      int          half;
      logic [16:0] step_root;
      logic [16:0] tw;
      logic [16:0] a;
      logic [16:0] t;
      lg = (log_size_reg < 1) ? 1 : (log_size_reg > 10) ? 10 : int'(log_size_reg);
      n = 1 << lg;
      for (int i = 0; i < n; i++) begin
         rev = 0;
         for (int b = 0; b < lg; b++) rev |= ((i >> b) & 1) << (lg - 1 - b);
         spectrum_mem[rev] = coeff_mem[i];
      end
      for (int s = 1; s <= lg; s++) begin
         span = 1 << s;
         half = span >> 1;
         step_root = inverse_reg ? GenInv : Gen;
         for (int k = 0; k < 16 - s; k++) step_root = mod_mul(step_root, step_root);
         for (int base = 0; base < n; base += span) begin
            tw = 17'd1;
            for (int j = 0; j < half; j++) begin
               a = spectrum_mem[base + j];
               t = mod_mul(tw, spectrum_mem[base + j + half]);
               spectrum_mem[base + j] = mod_add(a, t);
               spectrum_mem[base + j + half] = mod_sub(a, t);
               tw = mod_mul(tw, step_root);
            end
         end
      end
      if (inverse_reg) begin
         t = 17'(65537 - (65536 >> lg));
         for (int i = 0; i < n; i++) spectrum_mem[i] = mod_mul(spectrum_mem[i], t);
      end
   endtask

   // one request transfer, with predictor update
   task automatic send_item(input kind_type kind, input logic [9:0] idx,
                            input logic [16:0] val);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser = kind;
      req_tdata = {5'd0, val, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      case (kind)
         KIND_WRITE: begin
            coeff_mem[idx] = (val >= Modulus) ? 17'(val - Modulus) : val;
         end
         KIND_RUN: begin
            predict_transform();
            runs_done++;
         end
         KIND_READ: pending_reads.push_back('{value: spectrum_mem[idx], index: idx});
         default: ;
      endcase
      items_sent++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // result checker
   always @(posedge clock) begin
      read_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reads.size() == 0) begin
            report_mismatch("unexpected result index", int'(rsp_tdata[26:17]), -1);
         end else begin
            want = pending_reads.pop_front();
            if (rsp_tdata[16:0] !== want.value)
               report_mismatch("value_out", int'(rsp_tdata[16:0]), int'(want.value));
            if (rsp_tdata[26:17] !== want.index)
               report_mismatch("index_out", int'(rsp_tdata[26:17]), int'(want.index));
            reads_checked++;
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // wait until every result is back and the block is idle again
   task automatic wait_drained();
      int guard;
      guard = 0;
      while ((pending_reads.size() != 0 || !req_tready) && guard < 2000000) begin
         @(negedge clock);
         guard++;
      end
      repeat (20) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [3:0] val);
      wait_drained();
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wen <= 1'b0;
      if (idx == CSR_LOG_SIZE) log_size_reg = val;
      else inverse_reg = val[0];
   endtask

   function automatic int eff_points();
      int lg;
      lg = (log_size_reg < 1) ? 1 : (log_size_reg > 10) ? 10 : int'(log_size_reg);
      return 1 << lg;
   endfunction

   // load random coefficients for the current length, run, read back a share
   task automatic transform_round(input bit extreme_values, input int read_pct);
      int          n;
      logic [16:0] v;
      n = eff_points();
      for (int i = 0; i < n; i++) begin
         if (extreme_values) v = ($urandom_range(1)) ? 17'd65536 : 17'd0;
         else v = 17'($urandom_range(65536));
         send_item(KIND_WRITE, 10'(i), v);
      end
      send_item(KIND_RUN, 10'($urandom), 17'($urandom));
      for (int i = 0; i < n; i++)
         if ($urandom_range(99) < read_pct) send_item(KIND_READ, 10'(i), 17'($urandom));
   endtask

   // directed: extremes, each kind, out of range residue and length, unused kind
   task automatic test_directed();
      write_csr(CSR_LOG_SIZE, 4'd1);
      write_csr(CSR_INVERSE, 1'b0);
      send_item(KIND_WRITE, 10'd0, 17'd65536);
      send_item(KIND_WRITE, 10'd1, 17'h1FFFF);   // reduced before storing
      send_item(KIND_WRITE, 10'd1023, 17'd65537);
      send_item(KIND_NONE, 10'h3FF, 17'h1FFFF);  // ignored
      send_item(KIND_RUN, 10'd0, 17'd0);
      send_item(KIND_READ, 10'd0, 17'd0);
      send_item(KIND_READ, 10'd1, 17'd0);
      write_csr(CSR_LOG_SIZE, 4'd0);             // saturates to one
      write_csr(CSR_INVERSE, 1'b1);
      send_item(KIND_RUN, 10'd0, 17'd0);
      send_item(KIND_READ, 10'd0, 17'd0);
      send_item(KIND_READ, 10'd1, 17'd0);
      write_csr(CSR_LOG_SIZE, 4'd15);            // saturates to ten
      write_csr(CSR_INVERSE, 1'b0);
      transform_round(1'b1, 2);
      // read beyond the length after a short run
      write_csr(CSR_LOG_SIZE, 4'd2);
      send_item(KIND_RUN, 10'd0, 17'd0);
      send_item(KIND_READ, 10'd1023, 17'd0);
      send_item(KIND_READ, 10'd512, 17'd0);
   endtask

   // random rounds at small sizes with random noise and config changes
   task automatic test_random(input int item_budget);
      int stop_at;
      stop_at = items_sent + item_budget;
      while (items_sent < stop_at) begin
         write_csr(CSR_LOG_SIZE, 4'($urandom_range(1, 5)));
         write_csr(CSR_INVERSE, 1'($urandom));
         transform_round(1'b0, 75);
         // some noise: unused kind and rewrites of already loaded entries
         repeat ($urandom_range(3)) send_item(KIND_NONE, 10'($urandom), 17'($urandom));
         if ($urandom_range(3) == 0) begin
            send_item(KIND_WRITE, 10'($urandom_range(eff_points() - 1)), 17'($urandom));
            send_item(KIND_READ, 10'($urandom_range(eff_points() - 1)), 17'd0);
         end
      end
   endtask

   // sender waits for all results before carrying on
   task automatic test_drain_pause();
      send_idle_pct = 0;
      write_csr(CSR_LOG_SIZE, 4'd3);
      transform_round(1'b0, 75);
      wait_drained();
      send_item(KIND_READ, 10'd7, 17'd0);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = KIND_WRITE;
      rsp_tready = 1'b1;
      csr_wen = 1'b0;
      csr_index = CSR_LOG_SIZE;
      csr_wdata = '0;
      error_count = 0;
      items_sent = 0;
      reads_checked = 0;
      runs_done = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      log_size_reg = 4'd10;
      inverse_reg = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random(20);
      send_idle_pct = 74;
      test_random(20);
      send_idle_pct = 0;
      recv_stall_pct = 74;
      test_random(20);
      send_idle_pct = 35;
      recv_stall_pct = 35;
      test_random(20);
      test_drain_pause();
      recv_stall_pct = 0;
      // full-length inverse run over the coefficients already loaded
      write_csr(CSR_LOG_SIZE, 4'd10);
      write_csr(CSR_INVERSE, 1'b1);
      send_item(KIND_RUN, 10'd0, 17'd0);
      repeat (12) send_item(KIND_READ, 10'($urandom), 17'd0);
      wait_drained();
      repeat (50) @(negedge clock);

      $display("covered %0d items, %0d transforms, %0d reads checked", items_sent,
               runs_done, reads_checked);
      $display("lengths 2 to 1024, forward and inverse, under sender and receiver idling");
      if (pending_reads.size() != 0) report_mismatch("results missing", 0,
                                                     pending_reads.size());
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
